>>> rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg - shared types and constants for the binomial tree partner block
// Holds the sequencer states, the result limits and the control structs that
// pass between the sequencer and the bit-serial adder.
// ----------------------------------------------------------------------------
`default_nettype none

package btpc_pkg;

  // Most child results given for one request
  localparam int MAX_RESULTS = 10;
  // Width of the child count field
  localparam int CHILD_CNT_W = 4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_WRAP,
    ST_SCAN,
    ST_EMIT,
    ST_BAD
  } btpc_state_e;

  // Request to the bit-serial adder
  typedef struct packed {
    logic start;
    logic sub;
  } btpc_ser_req_t;

  // Status back from the bit-serial adder
  typedef struct packed {
    logic done;
    logic carry;
  } btpc_ser_stat_t;

endpackage

`default_nettype wire

>>> rtl/btpc_serial_add.sv
// ----------------------------------------------------------------------------
// btpc_serial_add - bit-serial adder / subtractor
// Shifts both operands out LSB first, one bit per cycle, and shifts the sum
// in from the top. When the last bit is in, it pulses done with the carry out.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_serial_add #(
  parameter int RANK_W = 10
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  btpc_pkg::btpc_ser_req_t  req_i,
  input  wire [RANK_W-1:0]         a_i,
  input  wire [RANK_W-1:0]         b_i,
  output btpc_pkg::btpc_ser_stat_t stat_o,
  output logic [RANK_W-1:0]        sum_o
);
  import btpc_pkg::*;

  localparam int CW = $clog2(RANK_W + 1);

  logic [RANK_W-1:0] a_q, a_d, b_q, b_d, r_q, r_d;
  logic              carry_q, carry_d, sub_q, sub_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              bit_b, bit_s;

  // One full-adder slice on the low bits
  assign bit_b = b_q[0] ^ sub_q;
  assign bit_s = a_q[0] ^ bit_b ^ carry_q;

  // Load on start, otherwise advance one bit while busy
  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    r_d     = r_q;
    carry_d = carry_q;
    sub_d   = sub_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    if (req_i.start) begin
      a_d     = a_i;
      b_d     = b_i;
      carry_d = req_i.sub;
      sub_d   = req_i.sub;
      busy_d  = 1'b1;
      cnt_d   = CW'(RANK_W - 1);
    end else if (busy_q) begin
      a_d     = a_q >> 1;
      b_d     = b_q >> 1;
      r_d     = {bit_s, r_q[RANK_W-1:1]};
      carry_d = (a_q[0] & bit_b) | (a_q[0] & carry_q) | (bit_b & carry_q);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift registers
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    r_q     <= r_d;
    carry_q <= carry_d;
    sub_q   <= sub_d;
  end

  assign stat_o.done  = done_q;
  assign stat_o.carry = carry_q;
  assign sum_o        = r_q;

endmodule

`default_nettype wire

>>> rtl/btpc_rotate.sv
// ----------------------------------------------------------------------------
// btpc_rotate - map a root-relative rank back to an absolute rank
// Adds the root rank and folds the sum once into the range below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_rotate #(
  parameter int RANK_W = 10
) (
  input  wire [RANK_W-1:0] rel_i,
  input  wire [RANK_W-1:0] root_i,
  input  wire [RANK_W:0]   count_i,
  output logic [RANK_W-1:0] rank_o
);

  logic [RANK_W:0] sum, folded;

  // Add, then subtract the count once if the sum wrapped past it
  always_comb begin
    sum    = {1'b0, rel_i} + {1'b0, root_i};
    folded = (sum >= count_i) ? (sum - count_i) : sum;
    rank_o = folded[RANK_W-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/binomial_tree_partner_calc.sv
// ----------------------------------------------------------------------------
// binomial_tree_partner_calc - parent and children in a rotated binomial tree
// Takes a rank and a root rank, finds the relative rank bit-serially, scans
// its bits one per cycle for the parent and the child count, then walks the
// bits again: one result per child in ascending bit order, one for a leaf.
// ----------------------------------------------------------------------------
//
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  in       | in_valid_i / in_ready_o, ranks       | request in
//  out      | out_valid_o / out_ready_i, results   | results out
//  cfg      | cfg_valid_i / cfg_ready_o, count     | register write
//
// One request at a time. A request runs the serial difference, a second serial
// pass that adds the count back when my_rank is below root_rank, the bit scan
// and the child walk; a bad rank goes straight to its flagged result. The
// serial adder and the one-bit-per-cycle scan set the pace. A stalled output
// holds the walk; a new request is taken while the final result of the
// previous one still waits. Reset sets the node count to one.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_tree_partner_calc #(
  parameter int MAX_RANKS = 1024
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [$clog2(MAX_RANKS):0]           cfg_node_count_i,
  // request
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire [$clog2(MAX_RANKS)-1:0]         my_rank_i,
  input  wire [$clog2(MAX_RANKS)-1:0]         root_rank_i,
  // results
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [$clog2(MAX_RANKS)-1:0]        parent_rank_o,
  output logic [$clog2(MAX_RANKS)-1:0]        child_rank_o,
  output logic                                child_valid_o,
  output logic [btpc_pkg::CHILD_CNT_W-1:0]    child_count_o,
  output logic                                bad_rank_o,
  output logic                                last_o
);
  import btpc_pkg::*;

  localparam int RANK_W = $clog2(MAX_RANKS);
  localparam int NCNT_W = RANK_W + 1;
  localparam int TOT_W  = $clog2(RANK_W + 1);
  localparam int WIDE_W = TOT_W + CHILD_CNT_W;
  localparam logic [CHILD_CNT_W-1:0] CNT_MAX = '1;

  btpc_state_e state_q, state_d;

  logic [NCNT_W-1:0] node_count_q, node_count_d;
  logic [RANK_W-1:0] root_q, root_d, rel_q, rel_d;
  logic [RANK_W-1:0] mask_q, mask_d, parent_q, parent_d;
  logic [TOT_W-1:0]  total_q, total_d, emit_n_q, emit_n_d;

  logic                   out_valid_q, out_valid_d;
  logic [RANK_W-1:0]      out_parent_q, out_parent_d, out_child_q, out_child_d;
  logic                   out_cvalid_q, out_cvalid_d;
  logic [CHILD_CNT_W-1:0] out_count_q, out_count_d;
  logic                   out_bad_q, out_bad_d, out_last_q, out_last_d;

  btpc_ser_req_t     ser_req;
  btpc_ser_stat_t    ser_stat;
  logic [RANK_W-1:0] ser_a, ser_b, ser_sum;
  logic [RANK_W-1:0] rot_in, rot_out;

  logic                   in_fire, bad_in, out_free, out_load;
  logic                   active, rel_hit, cand_ok, emit_last;
  logic [RANK_W-1:0]      cand;
  logic [WIDE_W-1:0]      total_wide;
  logic [CHILD_CNT_W-1:0] count_sat;
  logic [TOT_W-1:0]       n_lim;

  // Serial difference and wrap of the relative rank
  btpc_serial_add #(
    .RANK_W (RANK_W)
  ) u_serial_add (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ser_req),
    .a_i    (ser_a),
    .b_i    (ser_b),
    .stat_o (ser_stat),
    .sum_o  (ser_sum)
  );

  // Shared rotation back to absolute ranks
  btpc_rotate #(
    .RANK_W (RANK_W)
  ) u_rotate (
    .rel_i   (rot_in),
    .root_i  (root_q),
    .count_i (node_count_q),
    .rank_o  (rot_out)
  );

  // Handshake and scan conditions
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign bad_in      = ({1'b0, my_rank_i} >= node_count_q) ||
                       ({1'b0, root_rank_i} >= node_count_q);
  assign out_free    = !out_valid_q || out_ready_i;

  assign active  = (mask_q != '0) && ({1'b0, mask_q} < node_count_q);
  assign rel_hit = |(rel_q & mask_q);
  assign cand    = rel_q | mask_q;
  assign cand_ok = ({1'b0, cand} < node_count_q);
  assign rot_in  = (state_q == ST_SCAN) ? (rel_q & ~mask_q) : cand;

  // Saturate the child count and cap the number of results
  assign total_wide = {{CHILD_CNT_W{1'b0}}, total_q};
  assign count_sat  = (total_wide > {{TOT_W{1'b0}}, CNT_MAX}) ?
                      CNT_MAX : total_wide[CHILD_CNT_W-1:0];
  assign n_lim      = (total_wide > WIDE_W'(MAX_RESULTS)) ?
                      TOT_W'(MAX_RESULTS) : total_q;
  assign emit_last  = ((emit_n_q + TOT_W'(1)) == n_lim);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = bad_in ? ST_BAD : ST_DIFF;
      end
      ST_DIFF: begin
        if (ser_stat.done) state_d = ser_stat.carry ? ST_SCAN : ST_WRAP;
      end
      ST_WRAP: begin
        if (ser_stat.done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!active || rel_hit) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (total_q == '0) begin
          if (out_free) state_d = ST_IDLE;
        end else if (cand_ok && out_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and result loading
  always_comb begin
    ser_req      = '0;
    ser_a        = my_rank_i;
    ser_b        = root_rank_i;
    root_d       = root_q;
    rel_d        = rel_q;
    mask_d       = mask_q;
    parent_d     = parent_q;
    total_d      = total_q;
    emit_n_d     = emit_n_q;
    out_load     = 1'b0;
    out_parent_d = out_parent_q;
    out_child_d  = out_child_q;
    out_cvalid_d = out_cvalid_q;
    out_count_d  = out_count_q;
    out_bad_d    = out_bad_q;
    out_last_d   = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          root_d   = root_rank_i;
          parent_d = my_rank_i;
          if (!bad_in) begin
            ser_req.start = 1'b1;
            ser_req.sub   = 1'b1;
          end
        end
      end
      ST_DIFF: begin
        if (ser_stat.done) begin
          mask_d  = RANK_W'(1);
          total_d = '0;
          if (ser_stat.carry) begin
            rel_d = ser_sum;
          end else begin
            // my_rank below root_rank: add the count back
            ser_req.start = 1'b1;
            ser_req.sub   = 1'b0;
            ser_a         = ser_sum;
            ser_b         = node_count_q[RANK_W-1:0];
          end
        end
      end
      ST_WRAP: begin
        if (ser_stat.done) begin
          rel_d   = ser_sum;
          mask_d  = RANK_W'(1);
          total_d = '0;
        end
      end
      ST_SCAN: begin
        if (!active || rel_hit) begin
          if (active) parent_d = rot_out;
          mask_d   = RANK_W'(1);
          emit_n_d = '0;
        end else begin
          if (cand_ok) total_d = total_q + TOT_W'(1);
          mask_d = mask_q << 1;
        end
      end
      ST_EMIT: begin
        if (total_q == '0) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_parent_d = parent_q;
            out_child_d  = '0;
            out_cvalid_d = 1'b0;
            out_count_d  = count_sat;
            out_bad_d    = 1'b0;
            out_last_d   = 1'b1;
          end
        end else if (cand_ok) begin
          // Hold on a child until the output slot frees
          if (out_free) begin
            out_load     = 1'b1;
            out_parent_d = parent_q;
            out_child_d  = rot_out;
            out_cvalid_d = 1'b1;
            out_count_d  = count_sat;
            out_bad_d    = 1'b0;
            out_last_d   = emit_last;
            emit_n_d     = emit_n_q + TOT_W'(1);
            mask_d       = mask_q << 1;
          end
        end else begin
          mask_d = mask_q << 1;
        end
      end
      ST_BAD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_parent_d = '0;
          out_child_d  = '0;
          out_cvalid_d = 1'b0;
          out_count_d  = '0;
          out_bad_d    = 1'b1;
          out_last_d   = 1'b1;
        end
      end
      default: begin
        mask_d = mask_q;
      end
    endcase
  end

  // Output slot: fill on load, drop when taken
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Node count register, saturated on write
  always_comb begin
    node_count_d = node_count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      node_count_d = (cfg_node_count_i > NCNT_W'(MAX_RANKS)) ?
                     NCNT_W'(MAX_RANKS) : cfg_node_count_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      node_count_q <= NCNT_W'(1);
      total_q      <= '0;
      emit_n_q     <= '0;
      mask_q       <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      node_count_q <= node_count_d;
      total_q      <= total_d;
      emit_n_q     <= emit_n_d;
      mask_q       <= mask_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    root_q       <= root_d;
    rel_q        <= rel_d;
    parent_q     <= parent_d;
    out_parent_q <= out_parent_d;
    out_child_q  <= out_child_d;
    out_cvalid_q <= out_cvalid_d;
    out_count_q  <= out_count_d;
    out_bad_q    <= out_bad_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign parent_rank_o = out_parent_q;
  assign child_rank_o  = out_child_q;
  assign child_valid_o = out_cvalid_q;
  assign child_count_o = out_count_q;
  assign bad_rank_o    = out_bad_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

>>> rtl/btpc_checker.sv
// ----------------------------------------------------------------------------
// btpc_checker - port-level checks for the binomial tree partner block
// Watches the top level's ports and flags stalled results that change, results
// that break the result encoding, or requests taken while one is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_checker #(
  parameter int MAX_RANKS = 1024
) (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              in_valid_i,
  input wire                              in_ready_o,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire [$clog2(MAX_RANKS)-1:0]      parent_rank_o,
  input wire [$clog2(MAX_RANKS)-1:0]      child_rank_o,
  input wire                              child_valid_o,
  input wire [btpc_pkg::CHILD_CNT_W-1:0]  child_count_o,
  input wire                              bad_rank_o,
  input wire                              last_o
);
  import btpc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(child_rank_o) &&
      $stable(parent_rank_o) && $stable(last_o) && $stable(child_count_o))
    else $error("stalled result changed");

  // A result without a child carries a zero child rank
  a_no_child_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !child_valid_o |-> child_rank_o == '0)
    else $error("child rank set without child");

  // A bad-rank result is alone and empty
  a_bad_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_rank_o |-> last_o && !child_valid_o &&
      child_count_o == '0 && parent_rank_o == '0)
    else $error("bad-rank result not empty");

  // A real child implies a nonzero count
  a_child_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && child_valid_o |-> child_count_o != '0 && !bad_rank_o)
    else $error("child given with zero count");

  // One request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

endmodule

bind binomial_tree_partner_calc btpc_checker #(
  .MAX_RANKS (MAX_RANKS)
) u_btpc_checker (.*);

`default_nettype wire

>>> tb/sv/tb_binomial_tree_partner_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binomial_tree_partner_calc - self-checking bench for the partner block
// Drives rank / root requests through several node count settings, predicts
// the parent and the child list of every accepted request, and compares each
// result beat field by field against the oldest expected beat. The request
// side runs in bursts with gaps, and the result side stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_binomial_tree_partner_calc;

  localparam int MAX_RANKS = 1024;
  localparam int RANK_W    = $clog2(MAX_RANKS);
  localparam int CNT_W     = RANK_W + 1;
  localparam int NUM_PHASE = 10;
  localparam int PHASE_REQ = 48;
  // Idle cycles after the last result before touching the count register
  localparam int SETTLE    = 4 * RANK_W + 20;
  localparam int LIMIT     = 1000000;

  // One result beat of the block
  typedef struct {
    logic [RANK_W-1:0]              parent;
    logic [RANK_W-1:0]              child;
    logic                           child_ok;
    logic [btpc_pkg::CHILD_CNT_W-1:0] kids;
    logic                           bad;
    logic                           last;
  } partner_beat_t;

  // One directed request, tied to the phase whose count it targets
  typedef struct {
    int unsigned       phase;
    logic [RANK_W-1:0] me;
    logic [RANK_W-1:0] root;
  } rank_pair_t;

  // Result-side stall behavior
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SLOW,
    SINK_ALT
  } sink_mode_e;

  // --------------------------------------------------------------------------
  // Partner scoreboard: predicts the beats of each request and checks results
  // --------------------------------------------------------------------------
  class partner_scoreboard;
    int unsigned   node_count;
    partner_beat_t beat_q[$];
    int unsigned   errors;

    function new();
      node_count = 1;
      errors     = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      node_count = value;
    endfunction

    function int unsigned pending();
      return beat_q.size();
    endfunction

    // Rotate a relative rank back to an absolute one
    function int unsigned to_absolute(int unsigned rel, int unsigned root,
                                      int unsigned cnt);
      int unsigned x;
      x = rel + root;
      if (x >= cnt) x -= cnt;
      return x;
    endfunction

    // Work out parent and children of an accepted request
    function void note_request(logic [RANK_W-1:0] me, logic [RANK_W-1:0] root);
      int unsigned   cnt;
      int unsigned   rel;
      int unsigned   d;
      int unsigned   total;
      int unsigned   n;
      int unsigned   parent;
      int unsigned   kid_list[btpc_pkg::MAX_RESULTS];
      partner_beat_t b;
      cnt   = (node_count > MAX_RANKS) ? MAX_RANKS : node_count;
      total = 0;
      n     = 0;
      b.parent   = '0;
      b.child    = '0;
      b.child_ok = 1'b0;
      b.kids     = '0;
      b.bad      = 1'b0;
      b.last     = 1'b1;
      // Out of range ranks give one flagged beat
      if (me >= cnt || root >= cnt) begin
        b.bad = 1'b1;
        beat_q.push_back(b);
        return;
      end
      rel    = (me >= root) ? (me - root) : (me + cnt - root);
      parent = me;
      for (d = 1; d < cnt; d = d << 1) begin
        if ((rel & d) != 0) begin
          parent = to_absolute(rel ^ d, root, cnt);
          break;
        end
        if ((rel ^ d) < cnt) begin
          if (n < btpc_pkg::MAX_RESULTS) begin
            kid_list[n] = to_absolute(rel ^ d, root, cnt);
            n++;
          end
          total++;
        end
      end
      if (total > 15) total = 15;
      b.parent = parent[RANK_W-1:0];
      b.kids   = total[btpc_pkg::CHILD_CNT_W-1:0];
      // A leaf still gives one beat
      if (n == 0) begin
        beat_q.push_back(b);
        return;
      end
      for (int unsigned k = 0; k < n; k++) begin
        b.child    = kid_list[k][RANK_W-1:0];
        b.child_ok = 1'b1;
        b.last     = (k == n - 1);
        beat_q.push_back(b);
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v,
                                int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, name, exp_v, act_v);
      end
    endfunction

    // Check one result beat against the oldest expected beat
    function void check_result(partner_beat_t act);
      partner_beat_t e;
      if (beat_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual parent %0d child %0d",
                 $time, act.parent, act.child);
        return;
      end
      e = beat_q.pop_front();
      compare_field("parent_rank", e.parent, act.parent);
      compare_field("child_rank", e.child, act.child);
      compare_field("child_valid", e.child_ok, act.child_ok);
      compare_field("child_count", e.kids, act.kids);
      compare_field("bad_rank", e.bad, act.bad);
      compare_field("last", e.last, act.last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block instance
  // --------------------------------------------------------------------------
  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [CNT_W-1:0]                  cfg_node_count_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [RANK_W-1:0]                 my_rank_i;
  logic [RANK_W-1:0]                 root_rank_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [RANK_W-1:0]                 parent_rank_o;
  logic [RANK_W-1:0]                 child_rank_o;
  logic                              child_valid_o;
  logic [btpc_pkg::CHILD_CNT_W-1:0]  child_count_o;
  logic                              bad_rank_o;
  logic                              last_o;

  partner_scoreboard sb;
  int unsigned       cycle_cnt;
  int unsigned       burst_left;
  int unsigned       stall_left;
  sink_mode_e        sink_mode;
  rank_pair_t        directed_q[$];

  binomial_tree_partner_calc #(
    .MAX_RANKS(MAX_RANKS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_node_count_i(cfg_node_count_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .my_rank_i       (my_rank_i),
    .root_rank_i     (root_rank_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .parent_rank_o   (parent_rank_o),
    .child_rank_o    (child_rank_o),
    .child_valid_o   (child_valid_o),
    .child_count_o   (child_count_o),
    .bad_rank_o      (bad_rank_o),
    .last_o          (last_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("binomial_tree_partner_calc verification failed");
      $finish;
    end
  end

  // Note accepted requests and check accepted results
  always @(posedge clk_i) begin
    partner_beat_t act;
    if (rst_ni && in_valid_i && in_ready_o) sb.note_request(my_rank_i, root_rank_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      act.parent   = parent_rank_o;
      act.child    = child_rank_o;
      act.child_ok = child_valid_o;
      act.kids     = child_count_o;
      act.bad      = bad_rank_o;
      act.last     = last_o;
      sb.check_result(act);
    end
  end

  // Stall the result side, switching to a random mode after a random stretch
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      sink_mode  = sink_mode_e'($urandom_range(3, 0));
      stall_left = $urandom_range(200, 20);
    end
    stall_left--;
    case (sink_mode)
      SINK_OPEN: out_ready_i <= 1'b1;
      SINK_COIN: out_ready_i <= 1'($urandom_range(1, 0));
      SINK_SLOW: out_ready_i <= ($urandom_range(4, 0) == 0);
      default:   out_ready_i <= cycle_cnt[2];
    endcase
  end

  // Count setting of each phase; phase 0 keeps the reset value
  function automatic logic [CNT_W-1:0] phase_count(int unsigned phase);
    case (phase)
      0:       return CNT_W'(1);
      1:       return CNT_W'(MAX_RANKS);
      2:       return CNT_W'(0);
      3:       return {CNT_W{1'b1}};
      4:       return CNT_W'(1000);
      5:       return CNT_W'(2);
      6:       return CNT_W'(3);
      7:       return CNT_W'(MAX_RANKS - 1);
      8:       return CNT_W'(513);
      default: return CNT_W'($urandom_range((1 << CNT_W) - 1, 1));
    endcase
  endfunction

  // Present one request, hold it until taken, then maybe open a gap
  task automatic issue_request(logic [RANK_W-1:0] me, logic [RANK_W-1:0] root);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    my_rank_i   <= me;
    root_rank_i <= root;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(40, 20)
                                               : $urandom_range(8, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Hold off requests until every expected result has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write the node count while the block is idle
  task automatic write_node_count(logic [CNT_W-1:0] value);
    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_node_count_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_count(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Directed cases: extremes, root, leaves, wrap, bad ranks, saturation
  task automatic load_directed();
    directed_q.push_back('{0, 0, 0});
    directed_q.push_back('{0, 1, 0});
    directed_q.push_back('{0, 0, 1});
    directed_q.push_back('{1, 0, 0});
    directed_q.push_back('{1, 1023, 0});
    directed_q.push_back('{1, 0, 1023});
    directed_q.push_back('{1, 1023, 1023});
    directed_q.push_back('{1, 512, 0});
    directed_q.push_back('{1, 1, 0});
    directed_q.push_back('{1, 5, 3});
    directed_q.push_back('{1, 3, 5});
    directed_q.push_back('{1, 511, 512});
    directed_q.push_back('{1, 700, 300});
    directed_q.push_back('{2, 0, 0});
    directed_q.push_back('{3, 1023, 1000});
    directed_q.push_back('{3, 0, 0});
    directed_q.push_back('{4, 999, 0});
    directed_q.push_back('{4, 1000, 0});
    directed_q.push_back('{4, 0, 1000});
    directed_q.push_back('{4, 1023, 1023});
    directed_q.push_back('{6, 0, 0});
    directed_q.push_back('{6, 1, 0});
    directed_q.push_back('{6, 2, 1});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned       cnt_sat;
    int unsigned       pause_at;
    logic [RANK_W-1:0] me;
    logic [RANK_W-1:0] root;
    sb               = new();
    cycle_cnt        = 0;
    burst_left       = 0;
    stall_left       = 0;
    sink_mode        = SINK_OPEN;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_node_count_i = '0;
    in_valid_i       = 1'b0;
    my_rank_i        = '0;
    root_rank_i      = '0;
    out_ready_i      = 1'b0;
    load_directed();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned phase = 0; phase < NUM_PHASE; phase++) begin
      if (phase != 0) write_node_count(phase_count(phase));
      cnt_sat = (sb.node_count > MAX_RANKS) ? MAX_RANKS : sb.node_count;
      foreach (directed_q[j]) begin
        if (directed_q[j].phase == phase)
          issue_request(directed_q[j].me, directed_q[j].root);
      end
      pause_at = $urandom_range(PHASE_REQ - 8, 4);
      for (int unsigned i = 0; i < PHASE_REQ; i++) begin
        // Mostly in-range pairs, some raw values as noise
        if (cnt_sat > 0 && $urandom_range(7, 0) != 0) begin
          me   = RANK_W'($urandom_range(cnt_sat - 1, 0));
          root = RANK_W'($urandom_range(cnt_sat - 1, 0));
        end else begin
          me   = RANK_W'($urandom());
          root = RANK_W'($urandom());
        end
        issue_request(me, root);
        if (i == pause_at) drain_results();
      end
    end

    // Drain and let the block settle
    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("binomial_tree_partner_calc verification clean");
    end else begin
      $display("binomial_tree_partner_calc verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/btpc_pkg.sv
rtl/btpc_serial_add.sv
rtl/btpc_rotate.sv
rtl/binomial_tree_partner_calc.sv
rtl/btpc_checker.sv
tb/sv/tb_binomial_tree_partner_calc.sv
